// ===== hdl/minibox_edge_finder_defines.svh =====
// Assertion macros for the minibox edge finder checker.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef MINIBOX_EDGE_FINDER_DEFINES_SVH
`define MINIBOX_EDGE_FINDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBEF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mbef_pkg.sv =====
// Shared constants, types and helper functions of the minibox edge finder.
// Used by all RTL files but mbef_out_if and mbef_cfg_if; depends on nothing.
package mbef_pkg;

  // Sizing of the point store and the coordinate format.
  localparam int MAX_POINTS    = 64;
  localparam int MAX_DIM       = 8;
  localparam int COORD_WIDTH   = 32;
  localparam int RESULT_CAP    = 63;
  localparam int NUM_IN_COORDS = 8;

  // Derived widths.
  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_POINTS * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RES_W  = $clog2(RESULT_CAP + 1);

  // Opcodes of an input transaction.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_EDGE   = 2'd0;
  localparam logic [1:0] ST_NOEDGE = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [31:0]            in_coord_t;

  // Result of the shared compare unit.
  typedef struct packed {
    logic gt_lo;
    logic lt_hi;
  } cmp_res_t;

  // Reduce or sign-extend an incoming Q16.16 value to the stored width.
  function automatic coord_t to_coord(input in_coord_t raw);
    return coord_t'(raw);
  endfunction

  // Index of the last compared axis, with the register value clamped.
  function automatic logic [DIM_W-1:0] last_dim(input logic [3:0] dims);
    int d;
    d = int'(dims);
    if (d == 0) d = 1;
    if (d > MAX_DIM) d = MAX_DIM;
    return DIM_W'(d - 1);
  endfunction

endpackage

// ===== hdl/mbef_in_if.sv =====
// Input channel of the minibox edge finder: valid, ready and one command.
// Depends on mbef_pkg for the coordinate type.
interface mbef_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            opcode;
  mbef_pkg::in_coord_t   coord_0;
  mbef_pkg::in_coord_t   coord_1;
  mbef_pkg::in_coord_t   coord_2;
  mbef_pkg::in_coord_t   coord_3;
  mbef_pkg::in_coord_t   coord_4;
  mbef_pkg::in_coord_t   coord_5;
  mbef_pkg::in_coord_t   coord_6;
  mbef_pkg::in_coord_t   coord_7;
  logic [5:0]            row_index;

  modport source (output valid, opcode, coord_0, coord_1, coord_2, coord_3, coord_4,
                  coord_5, coord_6, coord_7, row_index, input ready);
  modport sink (input valid, opcode, coord_0, coord_1, coord_2, coord_3, coord_4,
                coord_5, coord_6, coord_7, row_index, output ready);
endinterface

// ===== hdl/mbef_out_if.sv =====
// Result channel of the minibox edge finder: valid, ready and one result.
// Depends on nothing.
interface mbef_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] first_index;
  logic [5:0] second_index;
  logic [1:0] status;
  logic       last;

  modport source (output valid, first_index, second_index, status, last, input ready);
  modport sink (input valid, first_index, second_index, status, last, output ready);
endinterface

// ===== hdl/mbef_cfg_if.sv =====
// Configuration write channel of the minibox edge finder.
// Carries the dims_in_use register value; depends on nothing.
interface mbef_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] dims_in_use;

  modport source (output valid, dims_in_use, input ready);
  modport sink (input valid, dims_in_use, output ready);
endinterface

// ===== hdl/mbef_point_store.sv =====
// Point store: one write port and one read port with registered read data.
// Depends on mbef_pkg for depth, address width and coordinate type.
module mbef_point_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [mbef_pkg::ADDR_W-1:0] waddr,
  input  mbef_pkg::coord_t            wdata,
  input  logic [mbef_pkg::ADDR_W-1:0] raddr,
  output mbef_pkg::coord_t            rdata
);

  mbef_pkg::coord_t mem [mbef_pkg::DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mbef_box_unit.sv =====
// Shared signed compare unit: tests one value against a lower and upper bound.
// Depends on mbef_pkg for the coordinate and result types.
module mbef_box_unit (
  input  mbef_pkg::coord_t   v,
  input  mbef_pkg::coord_t   lo,
  input  mbef_pkg::coord_t   hi,
  output mbef_pkg::cmp_res_t res
);

  // Strict comparisons; a value on the box border is not inside.
  assign res.gt_lo = (v > lo);
  assign res.lt_hi = (v < hi);

endmodule

// ===== hdl/minibox_edge_finder.sv =====
// Top level of the minibox edge finder: sequencer, point store and compare unit.
// Depends on mbef_pkg, the three channel interfaces, mbef_point_store, mbef_box_unit.
//
// Usage:
//   in_chan carries commands: load a point, query the edges of a row, clear the set.
//   out_chan carries results (edge, no edge in row, store full); the last result of a
//   command has last set. cfg_chan writes dims_in_use (reset 2) and is always ready.
//   The block takes one command at a time; in_chan.ready is high only when idle.
// Sequence (n stored points, d compared axes):
//   load: one store write per cycle through the single write port.
//   clear or unknown opcode: a settle state, then idle. Full-store load: waits for a free output slot.
//   query: load the d row coordinates, then per partner j > row load its d coordinates
//   and scan all n stored points on d axes; one coordinate is read from the store and
//   checked by the shared compare unit each cycle, and a partner stops early once
//   a point is found inside its box.
//   The first edge result is held back until a further edge (or the end of the scan) is
//   known, since the final one must carry last.
// Reset clears the point count and the output valid flag; store contents stay
// undefined and are never read before written. A stalled receiver holds one result
// in the output register; the sequencer waits only when it has a further result.
module minibox_edge_finder (
  input  logic        clk,
  input  logic        rst_n,
  mbef_in_if.sink     in_chan,
  mbef_out_if.source  out_chan,
  mbef_cfg_if.sink    cfg_chan
);

  localparam int MaxDim   = mbef_pkg::MAX_DIM;
  localparam int MaxPts   = mbef_pkg::MAX_POINTS;
  localparam int DimW     = mbef_pkg::DIM_W;
  localparam int PidxW    = mbef_pkg::PIDX_W;
  localparam int CntW     = mbef_pkg::CNT_W;
  localparam int AddrW    = mbef_pkg::ADDR_W;
  localparam int ResW     = mbef_pkg::RES_W;
  localparam int ResCap   = mbef_pkg::RESULT_CAP;
  localparam int NumInC   = mbef_pkg::NUM_IN_COORDS;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_FULL, S_SETTLE, S_ROW_LD, S_PAIR_LD, S_SCAN, S_EDGE,
    S_NEXT_J, S_FINISH
  } state_t;

  state_t               state_r, state_nxt;
  logic [CntW-1:0]      count_r, count_nxt;
  logic [3:0]           dims_r, dims_nxt;
  logic [5:0]           row_r, row_nxt;
  logic [CntW-1:0]      j_r, j_nxt;
  logic [ResW-1:0]      cnt_r, cnt_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [5:0]           pend_idx_r, pend_idx_nxt;
  logic [DimW-1:0]      wk_r, wk_nxt;
  logic [DimW-1:0]      iss_k_r, iss_k_nxt;
  logic [PidxW-1:0]     iss_y_r, iss_y_nxt;
  logic                 iss_done_r, iss_done_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [DimW-1:0]      rd_k_r, rd_k_nxt;
  logic                 rd_ylast_r, rd_ylast_nxt;
  logic                 acc_r, acc_nxt;
  mbef_pkg::coord_t     ld_coord_r [MaxDim];
  mbef_pkg::coord_t     ld_coord_nxt [MaxDim];
  mbef_pkg::coord_t     rowc_r [MaxDim];
  mbef_pkg::coord_t     rowc_nxt [MaxDim];
  mbef_pkg::coord_t     lo_r [MaxDim];
  mbef_pkg::coord_t     lo_nxt [MaxDim];
  mbef_pkg::coord_t     hi_r [MaxDim];
  mbef_pkg::coord_t     hi_nxt [MaxDim];
  logic                 out_valid_r, out_valid_nxt;
  logic [5:0]           out_first_r, out_first_nxt;
  logic [5:0]           out_second_r, out_second_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic                 out_last_r, out_last_nxt;

  mbef_pkg::in_coord_t  in_c [NumInC];
  logic [DimW-1:0]      last_k;
  logic                 slot_free;
  logic                 in_acc;
  logic                 phase_rd;
  logic                 leave;
  logic                 entry;
  logic                 issue;
  logic                 we;
  logic [AddrW-1:0]     waddr;
  logic [AddrW-1:0]     raddr;
  logic [PidxW-1:0]     ridx;
  mbef_pkg::coord_t     rdata;
  mbef_pkg::coord_t     cmp_lo;
  mbef_pkg::cmp_res_t   cmp;
  logic [CntW-1:0]      j_first;
  logic [CntW-1:0]      j_inc;

  // Incoming coordinates as an array.
  assign in_c[0] = in_chan.coord_0;
  assign in_c[1] = in_chan.coord_1;
  assign in_c[2] = in_chan.coord_2;
  assign in_c[3] = in_chan.coord_3;
  assign in_c[4] = in_chan.coord_4;
  assign in_c[5] = in_chan.coord_5;
  assign in_c[6] = in_chan.coord_6;
  assign in_c[7] = in_chan.coord_7;

  // Handshake and channel outputs.
  assign in_chan.ready         = (state_r == S_IDLE);
  assign in_acc                = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready        = 1'b1;
  assign slot_free             = !out_valid_r || out_chan.ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.first_index  = out_first_r;
  assign out_chan.second_index = out_second_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.last         = out_last_r;

  assign last_k   = mbef_pkg::last_dim(dims_r);
  assign phase_rd = (state_r == S_ROW_LD) || (state_r == S_PAIR_LD) || (state_r == S_SCAN);
  assign j_first  = CntW'(in_chan.row_index) + CntW'(1);
  assign j_inc    = j_r + CntW'(1);

  // Store read address: the row, the partner or the scanned point.
  always_comb begin
    case (state_r)
      S_ROW_LD:  ridx = PidxW'(row_r);
      S_PAIR_LD: ridx = PidxW'(j_r);
      default:   ridx = iss_y_r;
    endcase
  end
  assign raddr = AddrW'(int'(ridx) * MaxDim + int'(iss_k_r));
  assign waddr = AddrW'(int'(count_r) * MaxDim + int'(wk_r));
  assign we    = (state_r == S_WRITE);

  mbef_point_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (ld_coord_r[wk_r]),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The shared compare unit: the row coordinate during partner load, the box bounds
  // during the scan.
  assign cmp_lo = (state_r == S_PAIR_LD) ? rowc_r[rd_k_r] : lo_r[rd_k_r];

  mbef_box_unit u_box (
    .v   (rdata),
    .lo  (cmp_lo),
    .hi  (hi_r[rd_k_r]),
    .res (cmp)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    dims_nxt       = dims_r;
    row_nxt        = row_r;
    j_nxt          = j_r;
    cnt_nxt        = cnt_r;
    pend_vld_nxt   = pend_vld_r;
    pend_idx_nxt   = pend_idx_r;
    wk_nxt         = wk_r;
    iss_k_nxt      = iss_k_r;
    iss_y_nxt      = iss_y_r;
    iss_done_nxt   = iss_done_r;
    acc_nxt        = acc_r;
    ld_coord_nxt   = ld_coord_r;
    rowc_nxt       = rowc_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    leave          = 1'b0;
    entry          = 1'b0;

    if (cfg_chan.valid) begin
      dims_nxt = cfg_chan.dims_in_use;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_chan.opcode)
            mbef_pkg::OP_LOAD: begin
              if (int'(count_r) >= MaxPts) begin
                state_nxt = S_FULL;
              end else begin
                for (int k = 0; k < MaxDim; k++) begin
                  ld_coord_nxt[k] = mbef_pkg::to_coord(in_c[k]);
                end
                wk_nxt    = '0;
                state_nxt = S_WRITE;
              end
            end
            mbef_pkg::OP_QUERY: begin
              row_nxt      = in_chan.row_index;
              cnt_nxt      = '0;
              pend_vld_nxt = 1'b0;
              j_nxt        = j_first;
              if (int'(in_chan.row_index) + 1 >= int'(count_r)) begin
                state_nxt = S_FINISH;
              end else begin
                state_nxt = S_ROW_LD;
                entry     = 1'b1;
              end
            end
            mbef_pkg::OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_SETTLE;
            end
            default: begin
              state_nxt = S_SETTLE;
            end
          endcase
        end
      end
      S_WRITE: begin
        if (wk_r == DimW'(MaxDim - 1)) begin
          count_nxt = count_r + CntW'(1);
          state_nxt = S_IDLE;
        end else begin
          wk_nxt = wk_r + DimW'(1);
        end
      end
      S_FULL: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = '0;
          out_second_nxt = '0;
          out_status_nxt = mbef_pkg::ST_FULL;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SETTLE: begin
        state_nxt = S_IDLE;
      end
      S_ROW_LD: begin
        if (rd_vld_r) begin
          rowc_nxt[rd_k_r] = rdata;
          if (rd_k_r == last_k) begin
            leave     = 1'b1;
            entry     = 1'b1;
            state_nxt = S_PAIR_LD;
          end
        end
      end
      S_PAIR_LD: begin
        if (rd_vld_r) begin
          // Order the two coordinates into the box bounds of this axis.
          if (cmp.gt_lo) begin
            lo_nxt[rd_k_r] = rowc_r[rd_k_r];
            hi_nxt[rd_k_r] = rdata;
          end else begin
            lo_nxt[rd_k_r] = rdata;
            hi_nxt[rd_k_r] = rowc_r[rd_k_r];
          end
          if (rd_k_r == last_k) begin
            leave     = 1'b1;
            entry     = 1'b1;
            acc_nxt   = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_r) begin
          // A point is inside when it is strictly inside on every axis.
          if (rd_k_r == last_k) begin
            acc_nxt = 1'b1;
            if (acc_r && cmp.gt_lo && cmp.lt_hi) begin
              leave     = 1'b1;
              state_nxt = S_NEXT_J;
            end else if (rd_ylast_r) begin
              leave     = 1'b1;
              state_nxt = S_EDGE;
            end
          end else begin
            acc_nxt = acc_r && cmp.gt_lo && cmp.lt_hi;
          end
        end
      end
      S_EDGE: begin
        // Hold one edge back so that the final one can carry last.
        if (!pend_vld_r) begin
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = 6'(j_r);
          cnt_nxt      = cnt_r + ResW'(1);
          state_nxt    = S_NEXT_J;
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = row_r;
          out_second_nxt = pend_idx_r;
          out_status_nxt = mbef_pkg::ST_EDGE;
          out_last_nxt   = 1'b0;
          pend_idx_nxt   = 6'(j_r);
          cnt_nxt        = cnt_r + ResW'(1);
          state_nxt      = S_NEXT_J;
        end
      end
      S_NEXT_J: begin
        j_nxt = j_inc;
        if ((j_inc >= count_r) || (int'(cnt_r) == ResCap)) begin
          state_nxt = S_FINISH;
        end else begin
          entry     = 1'b1;
          state_nxt = S_PAIR_LD;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = row_r;
          out_last_nxt   = 1'b1;
          if (pend_vld_r) begin
            out_second_nxt = pend_idx_r;
            out_status_nxt = mbef_pkg::ST_EDGE;
          end else begin
            out_second_nxt = '0;
            out_status_nxt = mbef_pkg::ST_NOEDGE;
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Read issue: one store address per cycle while a read phase runs.
    issue        = phase_rd && !iss_done_r && !leave;
    rd_vld_nxt   = issue;
    rd_k_nxt     = iss_k_r;
    rd_ylast_nxt = (CntW'(iss_y_r) == (count_r - CntW'(1)));
    if (entry) begin
      iss_k_nxt    = '0;
      iss_y_nxt    = '0;
      iss_done_nxt = 1'b0;
    end else if (issue) begin
      if (iss_k_r == last_k) begin
        iss_k_nxt = '0;
        if ((state_r != S_SCAN) || rd_ylast_nxt) begin
          iss_done_nxt = 1'b1;
        end else begin
          iss_y_nxt = iss_y_r + PidxW'(1);
        end
      end else begin
        iss_k_nxt = iss_k_r + DimW'(1);
      end
    end
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dims_r      <= 4'd2;
      pend_vld_r  <= 1'b0;
      iss_done_r  <= 1'b1;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      dims_r       <= dims_nxt;
      row_r        <= row_nxt;
      j_r          <= j_nxt;
      cnt_r        <= cnt_nxt;
      pend_vld_r   <= pend_vld_nxt;
      pend_idx_r   <= pend_idx_nxt;
      wk_r         <= wk_nxt;
      iss_k_r      <= iss_k_nxt;
      iss_y_r      <= iss_y_nxt;
      iss_done_r   <= iss_done_nxt;
      rd_vld_r     <= rd_vld_nxt;
      rd_k_r       <= rd_k_nxt;
      rd_ylast_r   <= rd_ylast_nxt;
      acc_r        <= acc_nxt;
      ld_coord_r   <= ld_coord_nxt;
      rowc_r       <= rowc_nxt;
      lo_r         <= lo_nxt;
      hi_r         <= hi_nxt;
      out_valid_r  <= out_valid_nxt;
      out_first_r  <= out_first_nxt;
      out_second_r <= out_second_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

endmodule

// ===== hdl/mbef_checker.sv =====
// Port-level checker of the minibox edge finder, bound to the top level.
// Depends on mbef_pkg and the macros in minibox_edge_finder_defines.svh.
`include "minibox_edge_finder_defines.svh"

module mbef_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_first_index,
  input logic [5:0] out_second_index,
  input logic [1:0] out_status,
  input logic       out_last
);

  // Conditions on the offered result transaction.
  logic out_not_edge;
  logic out_full;
  logic out_zero_idx;

  assign out_not_edge = out_valid && (out_status != mbef_pkg::ST_EDGE);
  assign out_full     = out_valid && (out_status == mbef_pkg::ST_FULL);
  assign out_zero_idx = (out_first_index == 6'd0) && (out_second_index == 6'd0);

  // A stalled result stays offered.
  `MBEF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // The block works on one command at a time.
  `MBEF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // A no-edge or store-full result is always the only result of its command.
  `MBEF_ASSERT_SAME(a_single_last, out_not_edge, out_last, "single result without last")

  // A store-full result carries zero indices.
  `MBEF_ASSERT_SAME(a_full_zero, out_full, out_zero_idx, "store-full result with indices")

endmodule

bind minibox_edge_finder mbef_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_first_index  (out_chan.first_index),
  .out_second_index (out_chan.second_index),
  .out_status       (out_chan.status),
  .out_last         (out_chan.last)
);

// ===== tb/sv/tb_minibox_edge_finder.sv =====
// Self-checking testbench for the minibox edge finder: directed commands, then random point sets.
// Every result is checked against a predictor of the edge search or, for a typed row, its own expected result.
// Depends on mbef_pkg, mbef_in_if, mbef_out_if, mbef_cfg_if and minibox_edge_finder.
`timescale 1ns / 1ps

module tb_minibox_edge_finder;
  import mbef_pkg::*;

  // Opcode 3 has no meaning; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RAND_CMDS = 115;

  typedef struct packed {
    logic [5:0] first_idx;
    logic [5:0] second_idx;
    logic [1:0] status;
    logic       last;
  } pair_res_t;

  // One input transaction; a typed row carries its own expected result.
  typedef struct packed {
    logic [1:0]       opcode;
    logic [7:0][31:0] coords;
    logic [5:0]       row;
    bit               typed;
    pair_res_t        want;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mbef_in_if  in_if();
  mbef_out_if out_if();
  mbef_cfg_if cfg_if();

  minibox_edge_finder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Predictor state: the stored points, their count and the axis register.
  coord_t     pt_store [MAX_POINTS][MAX_DIM];
  int         pt_count = 0;
  logic [3:0] dims_reg = 4'd2;

  pair_res_t  row_pairs[$];
  pair_res_t  pending_pairs[$];
  bit         burst_mode = 1'b0;

  int err_count = 0;
  int n_cmds = 0;
  int n_cfg = 0;
  int n_edges = 0;
  int n_noedge = 0;
  int n_full = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // True when no stored point other than a and b lies strictly inside their box.
  function automatic bit box_is_empty(input int a, input int b, input int d);
    bit in_box;
    coord_t lo, hi, v;
    for (int y = 0; y < pt_count; y++) begin
      if (y == a || y == b) continue;
      in_box = 1'b1;
      for (int k = 0; k < d; k++) begin
        lo = (pt_store[a][k] <= pt_store[b][k]) ? pt_store[a][k] : pt_store[b][k];
        hi = (pt_store[a][k] <= pt_store[b][k]) ? pt_store[b][k] : pt_store[a][k];
        v = pt_store[y][k];
        if (v <= lo || v >= hi) begin
          in_box = 1'b0;
          break;
        end
      end
      if (in_box) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Updates the predictor state for one command and leaves its results in row_pairs.
  function automatic void predict_pairs(input cmd_t c);
    int d;
    int r;
    pair_res_t p;
    row_pairs.delete();
    case (c.opcode)
      OP_LOAD: begin
        if (pt_count >= MAX_POINTS) begin
          p = '{first_idx: 6'd0, second_idx: 6'd0, status: ST_FULL, last: 1'b1};
          row_pairs.push_back(p);
        end else begin
          for (int k = 0; k < MAX_DIM; k++) pt_store[pt_count][k] = coord_t'(c.coords[k]);
          pt_count++;
        end
      end
      OP_CLEAR: pt_count = 0;
      OP_QUERY: begin
        d = (dims_reg == 0) ? 1 : ((int'(dims_reg) > MAX_DIM) ? MAX_DIM : int'(dims_reg));
        r = int'(c.row);
        for (int j = r + 1; j < pt_count && row_pairs.size() < RESULT_CAP; j++) begin
          if (box_is_empty(r, j, d)) begin
            p = '{first_idx: c.row, second_idx: 6'(j), status: ST_EDGE, last: 1'b0};
            row_pairs.push_back(p);
          end
        end
        if (row_pairs.size() == 0) begin
          p = '{first_idx: c.row, second_idx: 6'd0, status: ST_NOEDGE, last: 1'b1};
          row_pairs.push_back(p);
        end else begin
          p = row_pairs.pop_back();
          p.last = 1'b1;
          row_pairs.push_back(p);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic cmd_t mk_cmd(input logic [1:0] op, input logic [31:0] c0,
                                  input logic [31:0] c1, input logic [31:0] rest,
                                  input logic [5:0] row);
    cmd_t c;
    c = '0;
    c.opcode = op;
    for (int k = 0; k < 8; k++) c.coords[k] = rest;
    c.coords[0] = c0;
    c.coords[1] = c1;
    c.row = row;
    return c;
  endfunction

  // A query whose only result is the empty-row marker.
  function automatic cmd_t noedge_query(input logic [5:0] row);
    cmd_t c;
    c = mk_cmd(OP_QUERY, '0, '0, '0, row);
    c.typed = 1'b1;
    c.want = '{first_idx: row, second_idx: 6'd0, status: ST_NOEDGE, last: 1'b1};
    return c;
  endfunction

  // Style 0 is full range, style 1 a coarse grid that forces ties, style 2 mostly extremes.
  function automatic logic [31:0] draw_coord(input int style);
    int v;
    case (style)
      0: return $urandom();
      1: begin
        v = int'($urandom_range(0, 6)) - 3;
        return 32'(v * 65536);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic cmd_t rand_cmd(input logic [1:0] op, input int style, input int row);
    cmd_t c;
    c = '0;
    c.opcode = op;
    for (int k = 0; k < 8; k++) c.coords[k] = draw_coord(style);
    c.row = 6'(row);
    return c;
  endfunction

  // Drives one command after a random gap, or none in burst mode, and records its expected results on acceptance.
  task automatic issue(input cmd_t c);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.opcode    <= c.opcode;
    in_if.coord_0   <= c.coords[0];
    in_if.coord_1   <= c.coords[1];
    in_if.coord_2   <= c.coords[2];
    in_if.coord_3   <= c.coords[3];
    in_if.coord_4   <= c.coords[4];
    in_if.coord_5   <= c.coords[5];
    in_if.coord_6   <= c.coords[6];
    in_if.coord_7   <= c.coords[7];
    in_if.row_index <= c.row;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_pairs(c);
    if (c.typed) pending_pairs.push_back(c.want);
    else foreach (row_pairs[i]) pending_pairs.push_back(row_pairs[i]);
    if (c.opcode != OP_UNUSED) n_cmds++;
  endtask

  // Writes the axis register once the block has drained.
  task automatic set_dims(input logic [3:0] v);
    in_if.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    // A load produces no result but keeps writing the store after it is accepted.
    repeat (2 * MAX_DIM + 4) @(posedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.dims_in_use <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    dims_reg = v;
    n_cfg++;
  endtask

  // Result side: random back-pressure (none in burst mode), then a field-by-field check of each transaction.
  initial begin
    int stall;
    pair_res_t exp_res;
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      if (pending_pairs.size() == 0) begin
        $error("unexpected result: first_index %0d second_index %0d status %0d last %0d",
               out_if.first_index, out_if.second_index, out_if.status, out_if.last);
        err_count++;
      end else begin
        exp_res = pending_pairs.pop_front();
        if (out_if.first_index !== exp_res.first_idx) begin
          $error("first_index: expected %0d, actual %0d", exp_res.first_idx,
                 out_if.first_index);
          err_count++;
        end
        if (out_if.second_index !== exp_res.second_idx) begin
          $error("second_index: expected %0d, actual %0d", exp_res.second_idx,
                 out_if.second_index);
          err_count++;
        end
        if (out_if.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_if.status);
          err_count++;
        end
        if (out_if.last !== exp_res.last) begin
          $error("last: expected %0d, actual %0d", exp_res.last, out_if.last);
          err_count++;
        end
        case (exp_res.status)
          ST_EDGE:   n_edges++;
          ST_NOEDGE: n_noedge++;
          default:   n_full++;
        endcase
      end
    end
  end

  // Stimulus: reset, the directed table, then random point sets under several axis settings.
  initial begin
    cmd_t directed_tbl[$];
    logic [3:0] dims_plan[5];
    int rand_start;
    int phase;
    int npts;
    int nq;
    int style;
    int row;
    bit big;

    in_if.valid        <= 1'b0;
    in_if.opcode       <= OP_LOAD;
    in_if.coord_0      <= '0;
    in_if.coord_1      <= '0;
    in_if.coord_2      <= '0;
    in_if.coord_3      <= '0;
    in_if.coord_4      <= '0;
    in_if.coord_5      <= '0;
    in_if.coord_6      <= '0;
    in_if.coord_7      <= '0;
    in_if.row_index    <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.dims_in_use <= 4'd2;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty store, extreme corners with a point between them, ties on one axis, the
    // ignored opcode, a clear, and a point strictly inside the box of two others on all axes.
    directed_tbl.push_back(noedge_query(6'd0));
    directed_tbl.push_back(noedge_query(6'd63));
    directed_tbl.push_back(mk_cmd(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 6'd0));
    directed_tbl.push_back(mk_cmd(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 6'd63));
    directed_tbl.push_back(mk_cmd(OP_LOAD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 6'd21));
    directed_tbl.push_back(mk_cmd(OP_QUERY, '0, '0, '0, 6'd0));
    directed_tbl.push_back(mk_cmd(OP_QUERY, '0, '0, '0, 6'd1));
    directed_tbl.push_back(noedge_query(6'd2));
    directed_tbl.push_back(noedge_query(6'd40));
    directed_tbl.push_back(mk_cmd(OP_LOAD, 32'h0000_0000, 32'h0005_0000, 32'hFFFF_FFFF, 6'd42));
    directed_tbl.push_back(mk_cmd(OP_LOAD, 32'h0000_0000, 32'hFFFB_0000, 32'h7FFF_FFFF, 6'd5));
    directed_tbl.push_back(mk_cmd(OP_QUERY, '0, '0, '0, 6'd2));
    directed_tbl.push_back(mk_cmd(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  6'd63));
    directed_tbl.push_back(mk_cmd(OP_QUERY, '0, '0, '0, 6'd0));
    directed_tbl.push_back(mk_cmd(OP_CLEAR, '0, '0, '0, 6'd0));
    directed_tbl.push_back(noedge_query(6'd0));
    directed_tbl.push_back(mk_cmd(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 6'd0));
    directed_tbl.push_back(mk_cmd(OP_LOAD, 32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF, 6'd0));
    directed_tbl.push_back(mk_cmd(OP_LOAD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 6'd0));
    directed_tbl.push_back(mk_cmd(OP_QUERY, '0, '0, '0, 6'd0));
    directed_tbl.push_back(mk_cmd(OP_QUERY, '0, '0, '0, 6'd1));
    foreach (directed_tbl[i]) issue(directed_tbl[i]);

    // Random part: each phase clears, loads a point set and queries some of its rows.
    // The third phase fills the store completely and overflows it.
    dims_plan = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd9};
    rand_start = n_cmds;
    phase = 0;
    while (n_cmds - rand_start < RAND_CMDS) begin
      big = (phase == 2);
      if (phase < 5) set_dims(dims_plan[phase]);
      else if ($urandom_range(0, 1) == 1) set_dims(4'($urandom_range(0, 15)));
      burst_mode = ($urandom_range(0, 3) == 0);
      style = $urandom_range(0, 2);
      issue(rand_cmd(OP_CLEAR, 0, $urandom_range(0, 63)));
      if ($urandom_range(0, 3) == 0) issue(rand_cmd(OP_QUERY, 0, $urandom_range(0, 63)));
      npts = big ? MAX_POINTS + 2 : $urandom_range(2, 10);
      for (int i = 0; i < npts; i++) begin
        issue(rand_cmd(OP_LOAD, style, $urandom_range(0, 63)));
        if ($urandom_range(0, 7) == 0) issue(rand_cmd(OP_UNUSED, 0, $urandom_range(0, 63)));
      end
      nq = big ? 2 : $urandom_range(2, 5);
      for (int q = 0; q < nq; q++) begin
        if (big) row = (q == 0) ? 0 : $urandom_range(0, 63);
        else if ($urandom_range(0, 5) == 0) row = $urandom_range(0, 63);
        else row = $urandom_range(0, npts - 1);
        issue(rand_cmd(OP_QUERY, 0, row));
      end
      phase++;
    end

    in_if.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    $display("Ran %0d commands over %0d point sets with %0d axis register writes.",
             n_cmds, phase + 1, n_cfg);
    $display("Checked %0d edge, %0d empty-row and %0d store-full results.",
             n_edges, n_noedge, n_full);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including full-store queries on eight axes.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mbef_pkg.sv
hdl/mbef_in_if.sv
hdl/mbef_out_if.sv
hdl/mbef_cfg_if.sv
hdl/mbef_point_store.sv
hdl/mbef_box_unit.sv
hdl/minibox_edge_finder.sv
hdl/mbef_checker.sv
tb/sv/tb_minibox_edge_finder.sv
